>>> rtl/core/cfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN rangefinder frame averager package
// Shared request types, register indexes, frame identifiers and the
// controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package cfa_pkg;

  localparam int DIST_W    = 30;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int ID_W      = 11;

  // Command codes carried in the cmd field of an input request.
  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Frame identifiers, compared on the low eleven bits only.
  localparam logic [ID_W-1:0] ID_FRONT = 11'h0D1;
  localparam logic [ID_W-1:0] ID_REAR  = 11'h0E1;
  localparam logic [ID_W-1:0] ID_RANGE = 11'h0CF;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALIVE_TMO    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FLAG_PERIOD  = 2'd2;

  localparam logic [13:0]       UM_PER_CM          = 14'd10000;
  localparam logic [CFG_W-1:0]  RESET_MAX_DIST_CM  = 16'd1600;
  localparam logic [CFG_W-1:0]  RESET_ALIVE_TMO    = 16'd500;
  localparam logic [CFG_W-1:0]  RESET_FLAG_PERIOD  = 16'd5000;
  localparam logic [DIST_W-1:0] RESET_LIMIT_UM     = 30'd16000000;

  typedef struct packed {
    logic        cmd;
    logic [31:0] now_ms;
    logic [28:0] can_id;
    logic [63:0] payload;
  } cfa_in_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance_um;
    logic              range_status;
    logic              sensor_alive;
    logic [31:0]       front_x;
    logic [31:0]       front_y;
    logic [31:0]       rear_x;
    logic [31:0]       rear_y;
  } cfa_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_TICK_DIV,
    ST_TICK_FIN,
    ST_LOAD
  } cfa_state_t;

  typedef struct packed {
    logic load_in;
    logic do_frame;
    logic div_init;
    logic div_step;
    logic do_tick;
    logic load_out;
  } cfa_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic count_nz;
    logic div_last;
    logic out_free;
  } cfa_sts_t;

endpackage

>>> rtl/core/cfa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame averager controller
// Sequences one request at a time through dispatch, division and result load.
// ----------------------------------------------------------------------------
module cfa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  cfa_pkg::cfa_sts_t sts,
  output cfa_pkg::cfa_cmd_t cmd
);

  cfa_pkg::cfa_state_t state;
  cfa_pkg::cfa_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cfa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      cfa_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = cfa_pkg::ST_DISPATCH;
        end
      end
      cfa_pkg::ST_DISPATCH: begin
        if (!sts.is_tick) begin
          cmd.do_frame = 1'b1;
          state_next   = cfa_pkg::ST_LOAD;
        end else if (sts.count_nz) begin
          cmd.div_init = 1'b1;
          state_next   = cfa_pkg::ST_TICK_DIV;
        end else begin
          state_next   = cfa_pkg::ST_TICK_FIN;
        end
      end
      cfa_pkg::ST_TICK_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = cfa_pkg::ST_TICK_FIN;
        end
      end
      cfa_pkg::ST_TICK_FIN: begin
        cmd.do_tick = 1'b1;
        state_next  = cfa_pkg::ST_LOAD;
      end
      cfa_pkg::ST_LOAD: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = cfa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cfa_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/cfa_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame averager datapath
// Configuration, sample accumulation, restoring divider, timing state and
// the output register.
// ----------------------------------------------------------------------------
module cfa_datapath #(
  parameter int MAX_SAMPLES = 255
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [cfa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cfa_pkg::CFG_W-1:0]           cfg_data,
  input  cfa_pkg::cfa_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output cfa_pkg::cfa_out_t                   out_data,
  input  cfa_pkg::cfa_cmd_t                   cmd,
  output cfa_pkg::cfa_sts_t                   sts
);

  localparam int CW     = $clog2(MAX_SAMPLES + 1);
  localparam int DW     = cfa_pkg::DIST_W;
  localparam int SUM_W  = DW + CW;
  localparam int STEP_W = $clog2(DW);

  // Configuration.
  logic [DW-1:0]              limit_um;
  logic [cfa_pkg::CFG_W-1:0]  alive_tmo;
  logic [cfa_pkg::CFG_W-1:0]  flag_period;

  // Captured request.
  cfa_pkg::cfa_in_t           req;

  // Block state.
  logic [SUM_W-1:0]           sample_sum;
  logic [CW-1:0]              sample_count;
  logic [DW-1:0]              held_distance;
  logic [DW-1:0]              reported_distance;
  logic                       status_good;
  logic [31:0]                last_frame_time;
  logic [31:0]                last_reading_time;
  logic [31:0]                flag_clear_time;
  logic [63:0]                front_coords;
  logic [63:0]                rear_coords;
  logic                       front_seen;
  logic                       rear_seen;

  // Divider.
  logic [CW-1:0]              div_rem;
  logic [DW-1:0]              div_q;
  logic [STEP_W-1:0]          div_cnt;
  logic [CW:0]                div_trial;
  logic                       div_ge;

  // Decode and timing.
  logic [cfa_pkg::ID_W-1:0]   raw_id;
  logic [31:0]                reading;
  logic [DW-1:0]              sample_val;
  logic [31:0]                since_frame;
  logic [31:0]                since_read;
  logic [31:0]                since_clear;
  logic [31:0]                tmo32;
  logic [31:0]                period32;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_um    <= cfa_pkg::RESET_LIMIT_UM;
      alive_tmo   <= cfa_pkg::RESET_ALIVE_TMO;
      flag_period <= cfa_pkg::RESET_FLAG_PERIOD;
    end else if (cfg_we) begin
      case (cfg_index)
        cfa_pkg::REG_MAX_DIST: begin
          limit_um <= DW'(cfg_data) * DW'(cfa_pkg::UM_PER_CM);
        end
        cfa_pkg::REG_ALIVE_TMO: begin
          alive_tmo <= cfg_data;
        end
        cfa_pkg::REG_FLAG_PERIOD: begin
          flag_period <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      req <= in_data;
    end
  end

  assign raw_id      = req.can_id[cfa_pkg::ID_W-1:0];
  assign reading     = req.payload[31:0];
  assign sample_val  = (reading >= {2'b00, limit_um}) ? '0 : reading[DW-1:0];
  assign tmo32       = {16'd0, alive_tmo};
  assign period32    = {16'd0, flag_period};
  assign since_frame = req.now_ms - last_frame_time;
  assign since_read  = req.now_ms - last_reading_time;
  assign since_clear = req.now_ms - flag_clear_time;

  // One quotient bit per cycle; the remainder always stays below the count.
  assign div_trial = {div_rem, div_q[DW-1]};
  assign div_ge    = div_trial >= {1'b0, sample_count};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      div_rem <= sample_sum[SUM_W-1:DW];
      div_q   <= sample_sum[DW-1:0];
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_rem <= div_ge ? CW'(div_trial - {1'b0, sample_count}) : div_trial[CW-1:0];
      div_q   <= {div_q[DW-2:0], div_ge};
      div_cnt <= div_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum        <= '0;
      sample_count      <= '0;
      held_distance     <= '0;
      reported_distance <= '0;
      status_good       <= 1'b0;
      last_frame_time   <= '0;
      last_reading_time <= '0;
      flag_clear_time   <= '0;
      front_coords      <= '0;
      rear_coords       <= '0;
      front_seen        <= 1'b0;
      rear_seen         <= 1'b0;
    end else if (cmd.do_frame) begin
      if (raw_id == cfa_pkg::ID_FRONT) begin
        front_coords <= req.payload;
        front_seen   <= 1'b1;
      end else if (raw_id == cfa_pkg::ID_REAR) begin
        rear_coords <= req.payload;
        rear_seen   <= 1'b1;
      end else if (raw_id == cfa_pkg::ID_RANGE) begin
        last_frame_time <= req.now_ms;
        if ((reading != 32'd0) && (sample_count < CW'(MAX_SAMPLES))) begin
          sample_sum   <= sample_sum + SUM_W'(sample_val);
          sample_count <= sample_count + 1'b1;
        end
      end
    end else if (cmd.do_tick) begin
      if (sample_count != '0) begin
        reported_distance <= div_q;
        held_distance     <= div_q;
        last_reading_time <= req.now_ms;
        status_good       <= 1'b1;
        sample_sum        <= '0;
        sample_count      <= '0;
      end else if (since_frame < tmo32) begin
        reported_distance <= held_distance;
        last_reading_time <= req.now_ms;
        status_good       <= 1'b1;
      end else if ((since_read > tmo32) && (since_frame > tmo32)) begin
        status_good <= 1'b0;
      end
      if (since_clear > period32) begin
        front_seen      <= 1'b0;
        rear_seen       <= 1'b0;
        flag_clear_time <= req.now_ms;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.distance_um  <= reported_distance;
      out_data.range_status <= status_good;
      out_data.sensor_alive <= front_seen | rear_seen;
      out_data.front_x      <= front_coords[31:0];
      out_data.front_y      <= front_coords[63:32];
      out_data.rear_x       <= rear_coords[31:0];
      out_data.rear_y       <= rear_coords[63:32];
    end
  end

  assign sts.is_tick  = (req.cmd == cfa_pkg::CMD_TICK);
  assign sts.count_nz = (sample_count != '0);
  assign sts.div_last = (div_cnt == STEP_W'(DW - 1));
  assign sts.out_free = !out_valid || !out_stall;

endmodule

>>> rtl/core/can_rangefinder_frame_averager.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN rangefinder frame averager
// Averages distance readings from range frames, reports them on update ticks
// and keeps the front and rear coordinate frames with their alive flags.
// ----------------------------------------------------------------------------
// The block takes one request at a time and returns exactly one result per
// request, showing the block state after that request. A frame request goes
// from dispatch to the load state, which waits for a free output register.
// An update tick without pending samples passes dispatch and a finish state;
// with samples, a restoring divider making one of the thirty quotient bits
// per cycle first forms the mean. A new request is accepted once the previous
// result sits in the output register, so a result that waits on a stalled
// consumer does not hold up the input side; only a second result waiting
// behind it does. The user must write configuration through cfg_we, cfg_index
// and cfg_data while no request is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module can_rangefinder_frame_averager #(
  parameter int MAX_SAMPLES = 255
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [cfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cfa_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  cfa_pkg::cfa_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output cfa_pkg::cfa_out_t             out_data
);

  // Commands from the controller and status back from the datapath.
  cfa_pkg::cfa_cmd_t cmd;
  cfa_pkg::cfa_sts_t sts;

  // The controller owns sequencing and the input handshake.
  cfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds configuration, accumulated samples, the divider,
  // the timing state and the output register.
  cfa_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Only one request is in flight: accepting one closes the input side.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while another is in flight");

  // A result is never written over one that is still waiting downstream.
  assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> sts.out_free)
    else $error("output register loaded while occupied");

  // The divider only runs for a tick with pending samples.
  assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (sts.is_tick && sts.count_nz))
    else $error("divider stepping without a tick and samples");

endmodule
